// ===== rtl/core/qrs_peak_classifier_assert.svh =====
// Assertion macros shared by the QRS peak classifier RTL.
`ifndef QRS_PEAK_CLASSIFIER_ASSERT_SVH
`define QRS_PEAK_CLASSIFIER_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define QPC_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define QPC_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

// ===== rtl/core/qpc_pkg.sv =====
//------------------------------------------------------------------------------
// qpc_pkg
// Shared types and constants of the QRS peak classifier.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package qpc_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int RR_HISTORY  = 8;

   localparam int unsigned CNT_BITS = 12;
   localparam logic [11:0] CNT_MAX  = 12'hFFF;
   localparam logic [7:0]  IRR_MAX  = 8'hFF;

   // Bound percentages over 100, scaled by 2^20 and rounded up, one per RR bound.
   localparam logic [20:0] RECIP_LOW  = 21'd964690;   // 0.92
   localparam logic [20:0] RECIP_HIGH = 21'd1216349;  // 1.16
   localparam logic [20:0] RECIP_MISS = 21'd1740637;  // 1.66

   localparam logic [2:0] CSR_REFRACTORY = 3'd0;
   localparam logic [2:0] CSR_SIG_START  = 3'd1;
   localparam logic [2:0] CSR_NOISE_START = 3'd2;
   localparam logic [2:0] CSR_RR_LOW     = 3'd3;
   localparam logic [2:0] CSR_RR_HIGH    = 3'd4;
   localparam logic [2:0] CSR_RR_MISS    = 3'd5;

   localparam logic ACT_SAMPLE  = 1'b0;
   localparam logic ACT_RESTART = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TEST,
      ST_AVG,
      ST_DIV,
      ST_BOUND,
      ST_CHECK,
      ST_SB_ADDR,
      ST_SB_READ,
      ST_SB_HIT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      BND_LOW,
      BND_HIGH,
      BND_MISS
   } bound_type;

   // Divider command and status between the controller and the divider.
   typedef struct packed {
      logic        start;
      logic [14:0] dividend;
      logic [3:0]  divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [14:0] quotient;
   } div_sts_type;

endpackage

// ===== rtl/core/qpc_divider.sv =====
//------------------------------------------------------------------------------
// qpc_divider
// Restoring divider, one quotient bit per cycle, for the RR averages.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpc_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  qpc_pkg::div_cmd_type cmd,
   output qpc_pkg::div_sts_type sts
);

   logic [14:0] quot_ff, quot_in;
   logic [4:0]  rem_ff, rem_in;
   logic [3:0]  div_ff, div_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[3:0], quot_ff[14]};
      if (cmd.start) begin
         quot_in = cmd.dividend;
         rem_in  = '0;
         div_in  = cmd.divisor;
         cnt_in  = 4'd15;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in  = trial - {1'b0, div_ff};
            quot_in = {quot_ff[13:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[13:0], 1'b0};
         end
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.quotient = quot_ff;

endmodule

// ===== rtl/core/qrs_peak_classifier.sv =====
// QRS peak classifier: one transaction on req_ yields exactly one on rsp_.
// A plain sample, or one that only gives a noise peak or an out-of-bound R
// peak, passes through the test, check and output states before rsp_tvalid
// rises. An R peak inside the RR bounds adds a sum of the RR history, the
// bit-serial average division and the three bounds. A search-back walk adds
// an address and a read step per stored peak read from the single-port peak
// ring, and a hit adds the signal update, a second division and the bounds.
// One item is in work at a time; a new request is taken after the response
// transaction.
//------------------------------------------------------------------------------
// qrs_peak_classifier
// Decision stage of a Pan-Tompkins style QRS detector with search-back.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "qrs_peak_classifier_assert.svh"

module qrs_peak_classifier #(
   parameter int PEAK_DEPTH  = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [qpc_pkg::SAMPLE_BITS-1:0] req_tdata,  // sample_value
   input  logic        req_tuser,             // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // r_peak_found, found_by_search_back, peak_value, rr_interval,
   // upper_threshold, irregular_count, zero fill
   output logic [55:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int SB   = qpc_pkg::SAMPLE_BITS;
   localparam int RR_HISTORY = qpc_pkg::RR_HISTORY;
   localparam int PW   = (PEAK_DEPTH > 1) ? $clog2(PEAK_DEPTH) : 1;
   localparam int HW   = $clog2(PEAK_DEPTH + 1);
   localparam int CW   = $clog2(RR_HISTORY + 1);
   localparam logic [HW-1:0] HELD_MAX = HW'(PEAK_DEPTH);

   // Peak ring: one synchronous single-port memory, height and gap per entry.
   logic [SB+11:0] ring_mem [PEAK_DEPTH];
   logic [SB+11:0] ring_rd_ff;
   logic           ring_we;
   logic [PW-1:0]  ring_addr;
   logic [SB+11:0] ring_wdata;

   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[ring_addr] <= ring_wdata;
      ring_rd_ff <= ring_mem[ring_addr];
   end

   // Configuration.
   logic [11:0] refr_ff, rlow_s_ff, rhigh_s_ff, rmiss_s_ff;
   logic [15:0] sig_s_ff, noise_s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         refr_ff    <= 12'd50;
         sig_s_ff   <= 16'd4000;
         noise_s_ff <= 16'd1000;
         rlow_s_ff  <= 12'd0;
         rhigh_s_ff <= 12'hFFF;
         rmiss_s_ff <= 12'hFFF;
      end else if (csr_we) begin
         case (csr_index)
            qpc_pkg::CSR_REFRACTORY:  refr_ff    <= csr_wdata[11:0];
            qpc_pkg::CSR_SIG_START:   sig_s_ff   <= csr_wdata;
            qpc_pkg::CSR_NOISE_START: noise_s_ff <= csr_wdata;
            qpc_pkg::CSR_RR_LOW:      rlow_s_ff  <= csr_wdata[11:0];
            qpc_pkg::CSR_RR_HIGH:     rhigh_s_ff <= csr_wdata[11:0];
            qpc_pkg::CSR_RR_MISS:     rmiss_s_ff <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // Detector state.
   qpc_pkg::state_type state_ff, state_in;
   logic [SB-1:0]  w0_ff, w0_in, w1_ff, w1_in, x_ff, x_in;
   logic [11:0]    sr_ff, sr_in, sa_ff, sa_in;
   logic [PW-1:0]  slot_ff, slot_in;
   logic [HW-1:0]  held_ff, held_in;
   logic [SB-1:0]  sig_ff, sig_in, noise_ff, noise_in, t1_ff, t1_in;
   logic [11:0]    blo_ff, blo_in, bhi_ff, bhi_in, bmi_ff, bmi_in;
   logic [11:0]    hall_ff [RR_HISTORY];
   logic [11:0]    hall_in [RR_HISTORY];
   logic [11:0]    hreg_ff [RR_HISTORY];
   logic [11:0]    hreg_in [RR_HISTORY];
   logic [7:0]     irr_ff, irr_in;
   logic           restart_ff, restart_in;
   // Result fields.
   logic           found_ff, found_in, bysb_ff, bysb_in;
   logic [15:0]    pval_ff, pval_in;
   logic [11:0]    rr_ff, rr_in;
   // Search-back walk.
   logic [PW-1:0]  idx_ff, idx_in;
   logic [HW-1:0]  k_ff, k_in;
   logic [12:0]    acc_ff, acc_in;
   logic           avg_all_ff, avg_all_in;  // average over all-RR history
   logic [11:0]    avg_ff, avg_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [14:0]    sum_ff, sum_in;
   logic           rv_ff, rv_in;
   qpc_pkg::bound_type bsel_ff, bsel_in;

   qpc_pkg::div_cmd_type div_cmd;
   qpc_pkg::div_sts_type div_sts;

   qpc_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   // Scale by a percentage with saturation: one multiply by a fixed-point
   // reciprocal, exact for every 12-bit average.
   logic [20:0] pct_recip;
   logic [32:0] prod;
   logic [12:0] scaled;
   logic [11:0] scaled_sat;
   always_comb begin
      case (bsel_ff)
         qpc_pkg::BND_LOW:  pct_recip = qpc_pkg::RECIP_LOW;
         qpc_pkg::BND_HIGH: pct_recip = qpc_pkg::RECIP_HIGH;
         default:           pct_recip = qpc_pkg::RECIP_MISS;
      endcase
      prod       = {21'b0, avg_ff} * {12'b0, pct_recip};
      scaled     = prod[32:20];
      scaled_sat = (scaled > 13'(qpc_pkg::CNT_MAX)) ? qpc_pkg::CNT_MAX : scaled[11:0];
   end

   function automatic logic [SB-1:0] thr(input logic [SB-1:0] n, input logic [SB-1:0] s);
      logic [SB+1:0] t;
      t = ({2'b0, n} * (SB+2)'(3) + {2'b0, s}) >> 2;
      return t[SB-1:0];
   endfunction

   logic [SB-1:0] p_mid, hgt;
   logic [11:0]   gap;
   logic          is_peak;
   logic [12:0]   ago;

   always_comb begin
      state_in = state_ff;
      w0_in = w0_ff; w1_in = w1_ff; x_in = x_ff;
      sr_in = sr_ff; sa_in = sa_ff;
      slot_in = slot_ff; held_in = held_ff;
      sig_in = sig_ff; noise_in = noise_ff; t1_in = t1_ff;
      blo_in = blo_ff; bhi_in = bhi_ff; bmi_in = bmi_ff;
      hall_in = hall_ff; hreg_in = hreg_ff;
      irr_in = irr_ff; restart_in = restart_ff;
      found_in = found_ff; bysb_in = bysb_ff; pval_in = pval_ff; rr_in = rr_ff;
      idx_in = idx_ff; k_in = k_ff; acc_in = acc_ff;
      avg_all_in = avg_all_ff; avg_in = avg_ff; cnt_in = cnt_ff; sum_in = sum_ff;
      rv_in = rv_ff; bsel_in = bsel_ff;
      div_cmd = '0;
      ring_we = 1'b0;
      ring_addr = idx_ff;
      ring_wdata = '0;
      req_tready = 1'b0;
      p_mid = w1_ff;
      hgt = ring_rd_ff[SB+11:12];
      gap = ring_rd_ff[11:0];
      is_peak = 1'b0;
      ago = 13'(sa_ff) + acc_ff;

      case (state_ff)
         qpc_pkg::ST_IDLE: begin
            req_tready = !rv_ff;
            if (req_tvalid && !rv_ff) begin
               x_in = req_tdata;
               found_in = 1'b0; bysb_in = 1'b0; pval_in = '0; rr_in = '0;
               if (req_tuser == qpc_pkg::ACT_RESTART) begin
                  w0_in = '0; w1_in = '0; sr_in = '0; sa_in = '0;
                  slot_in = '0; held_in = '0;
                  sig_in = SB'(sig_s_ff); noise_in = SB'(noise_s_ff);
                  t1_in = thr(SB'(noise_s_ff), SB'(sig_s_ff));
                  blo_in = rlow_s_ff; bhi_in = rhigh_s_ff; bmi_in = rmiss_s_ff;
                  for (int i = 0; i < RR_HISTORY; i++) begin
                     hall_in[i] = '0; hreg_in[i] = '0;
                  end
                  irr_in = '0;
                  state_in = qpc_pkg::ST_OUT;
               end else begin
                  if (sr_ff != qpc_pkg::CNT_MAX) sr_in = sr_ff + 12'd1;
                  if (sa_ff != qpc_pkg::CNT_MAX) sa_in = sa_ff + 12'd1;
                  state_in = qpc_pkg::ST_TEST;
               end
            end
         end
         qpc_pkg::ST_TEST: begin
            is_peak = (w0_ff < w1_ff) && (w1_ff > x_ff) && (sr_ff >= refr_ff);
            state_in = qpc_pkg::ST_CHECK;
            if (is_peak) begin
               ring_we = 1'b1;
               ring_addr = slot_ff;
               ring_wdata = {p_mid, sa_ff};
               slot_in = (slot_ff == PW'(PEAK_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
               if (held_ff != HELD_MAX) held_in = held_ff + 1'b1;
               sa_in = '0;
               if (p_mid > t1_ff) begin
                  for (int i = RR_HISTORY - 1; i > 0; i--) hall_in[i] = hall_ff[i-1];
                  hall_in[0] = sr_ff;
                  found_in = 1'b1; pval_in = 16'(p_mid); rr_in = sr_ff;
                  sr_in = '0;
                  if (blo_ff < sr_ff && sr_ff < bhi_ff) begin
                     for (int i = RR_HISTORY - 1; i > 0; i--) hreg_in[i] = hreg_ff[i-1];
                     hreg_in[0] = sr_ff;
                     sig_in = SB'(({3'b0, p_mid} + {3'b0, sig_ff} * (SB+3)'(7)) >> 3);
                     irr_in = '0;
                     avg_all_in = 1'b0;
                     state_in = qpc_pkg::ST_AVG;
                  end else if (irr_ff != qpc_pkg::IRR_MAX) begin
                     irr_in = irr_ff + 8'd1;
                  end
               end else begin
                  noise_in = SB'(({3'b0, p_mid} + {3'b0, noise_ff} * (SB+3)'(7)) >> 3);
                  t1_in = thr(SB'(({3'b0, p_mid} + {3'b0, noise_ff} * (SB+3)'(7)) >> 3),
                              sig_ff);
               end
            end
         end
         qpc_pkg::ST_AVG: begin
            sum_in = '0; cnt_in = '0;
            for (int i = 0; i < RR_HISTORY; i++) begin
               if ((avg_all_ff ? hall_ff[i] : hreg_ff[i]) != 12'd0) begin
                  sum_in = sum_in + 15'(avg_all_ff ? hall_ff[i] : hreg_ff[i]);
                  cnt_in = cnt_in + 1'b1;
               end
            end
            state_in = qpc_pkg::ST_DIV;
            div_cmd.start = 1'b1;
            div_cmd.dividend = sum_in;
            div_cmd.divisor = 4'(cnt_in);
         end
         qpc_pkg::ST_DIV: begin
            if (div_sts.done) begin
               avg_in = (cnt_ff == '0) ? 12'd0 : div_sts.quotient[11:0];
               t1_in = thr(noise_ff, sig_ff);
               bsel_in = qpc_pkg::BND_LOW;
               state_in = qpc_pkg::ST_BOUND;
            end
         end
         qpc_pkg::ST_BOUND: begin
            case (bsel_ff)
               qpc_pkg::BND_LOW: begin
                  blo_in = scaled_sat; bsel_in = qpc_pkg::BND_HIGH;
               end
               qpc_pkg::BND_HIGH: begin
                  bhi_in = scaled_sat; bsel_in = qpc_pkg::BND_MISS;
               end
               default: begin
                  bmi_in = scaled_sat;
                  state_in = avg_all_ff ? qpc_pkg::ST_OUT : qpc_pkg::ST_CHECK;
               end
            endcase
         end
         qpc_pkg::ST_CHECK: begin
            idx_in = slot_ff;
            k_in = '0;
            acc_in = '0;
            if (sr_ff > bmi_ff && held_ff != '0) state_in = qpc_pkg::ST_SB_ADDR;
            else state_in = qpc_pkg::ST_OUT;
         end
         qpc_pkg::ST_SB_ADDR: begin
            idx_in = (idx_ff == '0) ? PW'(PEAK_DEPTH - 1) : idx_ff - 1'b1;
            ring_addr = idx_in;
            state_in = qpc_pkg::ST_SB_READ;
         end
         qpc_pkg::ST_SB_READ: begin
            if (hgt > (t1_ff >> 1) && hgt < t1_ff) begin
               found_in = 1'b1; bysb_in = 1'b1; pval_in = 16'(hgt);
               rr_in = (13'(sr_ff) > ago) ? 12'(13'(sr_ff) - ago) : 12'd0;
               state_in = qpc_pkg::ST_SB_HIT;
            end else if (hgt > t1_ff) begin
               state_in = qpc_pkg::ST_OUT;
            end else begin
               acc_in = (ago + 13'(gap) > 13'(qpc_pkg::CNT_MAX)) ?
                        13'(qpc_pkg::CNT_MAX) - 13'(sa_ff) : acc_ff + 13'(gap);
               k_in = k_ff + 1'b1;
               if (k_ff + 1'b1 == held_ff) state_in = qpc_pkg::ST_OUT;
               else state_in = qpc_pkg::ST_SB_ADDR;
            end
         end
         qpc_pkg::ST_SB_HIT: begin
            sig_in = SB'(({2'b0, pval_ff[SB-1:0]} + {2'b0, sig_ff} * (SB+2)'(3)) >> 2);
            for (int i = RR_HISTORY - 1; i > 0; i--) hall_in[i] = hall_ff[i-1];
            hall_in[0] = rr_ff;
            sr_in = '0;
            avg_all_in = 1'b1;
            state_in = qpc_pkg::ST_AVG;
         end
         qpc_pkg::ST_OUT: begin
            w0_in = w1_ff;
            w1_in = x_ff;
            if (restart_ff) begin
               w0_in = '0; w1_in = '0;
            end
            restart_in = 1'b0;
            rv_in = 1'b1;
            state_in = qpc_pkg::ST_IDLE;
         end
         default: state_in = qpc_pkg::ST_IDLE;
      endcase
      if (state_ff == qpc_pkg::ST_IDLE && req_tvalid && !rv_ff)
         restart_in = (req_tuser == qpc_pkg::ACT_RESTART);
      if (rv_ff && rsp_tready) rv_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qpc_pkg::ST_IDLE;
         rv_ff <= 1'b0;
         restart_ff <= 1'b0;
         w0_ff <= '0; w1_ff <= '0;
         sr_ff <= '0; sa_ff <= '0;
         slot_ff <= '0; held_ff <= '0;
         sig_ff <= SB'(16'd4000); noise_ff <= SB'(16'd1000);
         t1_ff <= thr(SB'(16'd1000), SB'(16'd4000));
         blo_ff <= 12'd0; bhi_ff <= 12'hFFF; bmi_ff <= 12'hFFF;
         for (int i = 0; i < RR_HISTORY; i++) begin
            hall_ff[i] <= '0; hreg_ff[i] <= '0;
         end
         irr_ff <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         restart_ff <= restart_in;
         w0_ff <= w0_in; w1_ff <= w1_in;
         sr_ff <= sr_in; sa_ff <= sa_in;
         slot_ff <= slot_in; held_ff <= held_in;
         sig_ff <= sig_in; noise_ff <= noise_in; t1_ff <= t1_in;
         blo_ff <= blo_in; bhi_ff <= bhi_in; bmi_ff <= bmi_in;
         hall_ff <= hall_in; hreg_ff <= hreg_in;
         irr_ff <= irr_in;
      end
      x_ff <= x_in;
      found_ff <= found_in; bysb_ff <= bysb_in; pval_ff <= pval_in; rr_ff <= rr_in;
      idx_ff <= idx_in; k_ff <= k_in; acc_ff <= acc_in;
      avg_all_ff <= avg_all_in; avg_ff <= avg_in; cnt_ff <= cnt_in; sum_ff <= sum_in;
      bsel_ff <= bsel_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {2'b0, irr_ff, 16'(t1_ff), rr_ff, pval_ff, bysb_ff, found_ff};

   `QPC_ASSERT_IMPL(a_one_in_flight, clock, reset, req_tvalid && req_tready, !rsp_tvalid,
      "request accepted while a response is pending")
   `QPC_ASSERT_IMPL(a_sb_flag, clock, reset, rsp_tvalid && rsp_tdata[1], rsp_tdata[0],
      "search-back flag without an R peak")
   `QPC_ASSERT_NEXT(a_div_idle, clock, reset, div_cmd.start, div_sts.busy,
      "divider did not start")
   `QPC_ASSERT_IMPL(a_held_range, clock, reset, 1'b1, held_ff <= HELD_MAX,
      "peak count beyond ring depth")

endmodule

// ===== bench/qrs_peak_classifier_tb.sv =====
//------------------------------------------------------------------------------
// qrs_peak_classifier_tb
// Self-checking bench for the QRS peak classifier. Synthetic ECG-like streams
// (baseline, beats, small peaks, missed beats, noise and restarts) are driven
// through the request stream. A behavioral copy of the decision stage predicts
// every response transaction, which is compared field by field. The run covers
// several register settings, the extremes among them, and several patterns of
// backpressure.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrs_peak_classifier_tb;

   typedef struct packed {
      logic        action;
      logic [15:0] value;
   } sample_item_type;

   // Fields from the highest bit down, matching the response layout.
   typedef struct packed {
      logic [7:0]  irregular;
      logic [15:0] threshold;
      logic [11:0] rr;
      logic [15:0] height;
      logic        by_search;
      logic        found;
   } beat_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   sample_item_type pending_q[$];
   beat_result_type expected_q[$];
   sample_item_type cur_item;

   int sender_idle_pct;
   int receiver_idle_pct;
   int n_errors;
   int n_sent;
   int n_beats;
   int n_search_hits;

   // Register copies and detector state of the predictor.
   int cfg_refractory, cfg_sig_start, cfg_noise_start;
   int cfg_rr_low, cfg_rr_high, cfg_rr_miss;
   int win0, win1, since_r, since_any;
   int ring_height[128];
   int ring_gap[128];
   int ring_slot, ring_held;
   int sig_lvl, noise_lvl, thr_upper, thr_lower;
   int bound_low, bound_high, bound_miss;
   int rr_all[8];
   int rr_regular[8];
   int regular_avg, irregular;

   qrs_peak_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic int mean_nonzero(int h[8]);
      int sum;
      int cnt;
      sum = 0;
      cnt = 0;
      for (int i = 0; i < 8; i++) begin
         if (h[i] != 0) begin
            sum += h[i];
            cnt++;
         end
      end
      return (cnt != 0) ? (sum / cnt) & 12'hFFF : 0;
   endfunction

   function automatic int scale_pct(int avg, int pct);
      int v;
      v = (avg * pct) / 100;
      return (v > 4095) ? 4095 : v;
   endfunction

   task automatic update_thresholds();
      thr_upper = ((3 * noise_lvl + sig_lvl) / 4) & 16'hFFFF;
      thr_lower = thr_upper / 2;
   endtask

   task automatic update_bounds(int avg);
      bound_low  = scale_pct(avg, 92);
      bound_high = scale_pct(avg, 116);
      bound_miss = scale_pct(avg, 166);
   endtask

   task automatic restart_detector();
      win0 = 0;
      win1 = 0;
      since_r = 0;
      since_any = 0;
      ring_slot = 0;
      ring_held = 0;
      sig_lvl = cfg_sig_start;
      noise_lvl = cfg_noise_start;
      update_thresholds();
      bound_low = cfg_rr_low;
      bound_high = cfg_rr_high;
      bound_miss = cfg_rr_miss;
      for (int i = 0; i < 8; i++) begin
         rr_all[i] = 0;
         rr_regular[i] = 0;
      end
      regular_avg = 0;
      irregular = 0;
   endtask

   // Works out the response to one accepted sample and advances the state.
   task automatic classify_sample(sample_item_type item);
      beat_result_type r;
      int x, p, rr, idx, acc, ago;
      r = '0;
      x = int'(item.value);
      if (item.action == qpc_pkg::ACT_RESTART) begin
         restart_detector();
      end else begin
         if (since_r < 4095) since_r++;
         if (since_any < 4095) since_any++;
         if (win0 < win1 && win1 > x && since_r >= cfg_refractory) begin
            p = win1;
            ring_height[ring_slot] = p;
            ring_gap[ring_slot] = since_any;
            if (p > thr_upper) begin
               rr = since_r;
               for (int i = 7; i > 0; i--) rr_all[i] = rr_all[i-1];
               rr_all[0] = rr;
               if (bound_low < rr && rr < bound_high) begin
                  for (int i = 7; i > 0; i--) rr_regular[i] = rr_regular[i-1];
                  rr_regular[0] = rr;
                  regular_avg = mean_nonzero(rr_regular);
                  sig_lvl = ((p + 7 * sig_lvl) / 8) & 16'hFFFF;
                  update_bounds(regular_avg);
                  update_thresholds();
                  irregular = 0;
               end else if (irregular < 255) begin
                  irregular++;
               end
               since_r = 0;
               r.found = 1'b1;
               r.height = 16'(p);
               r.rr = 12'(rr);
            end else begin
               noise_lvl = ((p + 7 * noise_lvl) / 8) & 16'hFFFF;
               update_thresholds();
            end
            ring_slot = (ring_slot + 1) % 128;
            if (ring_held < 128) ring_held++;
            since_any = 0;
         end
         if (since_r > bound_miss) begin
            // Walk back from the newest stored peak looking for a missed beat.
            acc = 0;
            idx = ring_slot;
            for (int k = 0; k < ring_held; k++) begin
               idx = (idx + 127) % 128;
               p = ring_height[idx];
               if (p > thr_lower && p < thr_upper) begin
                  ago = since_any + acc;
                  rr = (since_r > ago) ? since_r - ago : 0;
                  sig_lvl = ((p + 3 * sig_lvl) / 4) & 16'hFFFF;
                  for (int i = 7; i > 0; i--) rr_all[i] = rr_all[i-1];
                  rr_all[0] = rr;
                  update_bounds(mean_nonzero(rr_all));
                  update_thresholds();
                  since_r = 0;
                  r.found = 1'b1;
                  r.by_search = 1'b1;
                  r.height = 16'(p);
                  r.rr = 12'(rr);
                  break;
               end else if (p > thr_upper) begin
                  break;
               end
               acc += ring_gap[idx];
            end
         end
         win0 = win1;
         win1 = x;
      end
      r.threshold = 16'(thr_upper);
      r.irregular = 8'(irregular);
      expected_q.push_back(r);
   endtask

   // Request driver: one transaction per handshake, random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            classify_sample(cur_item);
            n_sent++;
         end
         if (pending_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            cur_item = pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= cur_item.value;
            req_tuser <= cur_item.action;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response monitor with random backpressure.
   always @(posedge clock) begin
      beat_result_type act, exp_r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            act = rsp_tdata[53:0];
            if (act.found) n_beats++;
            if (act.by_search) n_search_hits++;
            if (expected_q.size() == 0) begin
               $error("response transaction with nothing expected: %h", rsp_tdata);
               n_errors++;
            end else begin
               exp_r = expected_q.pop_front();
               if (act.found !== exp_r.found) begin
                  $error("r_peak_found: expected %0d, got %0d", exp_r.found, act.found);
                  n_errors++;
               end
               if (act.by_search !== exp_r.by_search) begin
                  $error("found_by_search_back: expected %0d, got %0d",
                         exp_r.by_search, act.by_search);
                  n_errors++;
               end
               if (act.height !== exp_r.height) begin
                  $error("peak_value: expected %0d, got %0d", exp_r.height, act.height);
                  n_errors++;
               end
               if (act.rr !== exp_r.rr) begin
                  $error("rr_interval: expected %0d, got %0d", exp_r.rr, act.rr);
                  n_errors++;
               end
               if (act.threshold !== exp_r.threshold) begin
                  $error("upper_threshold: expected %0d, got %0d",
                         exp_r.threshold, act.threshold);
                  n_errors++;
               end
               if (act.irregular !== exp_r.irregular) begin
                  $error("irregular_count: expected %0d, got %0d",
                         exp_r.irregular, act.irregular);
                  n_errors++;
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   task automatic add_sample(int value);
      pending_q.push_back('{action: qpc_pkg::ACT_SAMPLE, value: value[15:0]});
   endtask

   task automatic add_restart();
      pending_q.push_back('{action: qpc_pkg::ACT_RESTART,
                            value: 16'($urandom_range(0, 65535))});
   endtask

   // Waits until the block has gone quiet, then lets its latency run out.
   task automatic wait_drained();
      wait (pending_q.size() == 0 && !req_tvalid && expected_q.size() == 0);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[15:0];
   endtask

   task automatic write_registers(int refr, int sig, int noise, int lo, int hi, int miss);
      write_csr(qpc_pkg::CSR_REFRACTORY, refr);
      write_csr(qpc_pkg::CSR_SIG_START, sig);
      write_csr(qpc_pkg::CSR_NOISE_START, noise);
      write_csr(qpc_pkg::CSR_RR_LOW, lo);
      write_csr(qpc_pkg::CSR_RR_HIGH, hi);
      write_csr(qpc_pkg::CSR_RR_MISS, miss);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_refractory = refr & 12'hFFF;
      cfg_sig_start = sig & 16'hFFFF;
      cfg_noise_start = noise & 16'hFFFF;
      cfg_rr_low = lo & 12'hFFF;
      cfg_rr_high = hi & 12'hFFF;
      cfg_rr_miss = miss & 12'hFFF;
   endtask

   // Queues roughly n samples of an ECG-like stream.
   task automatic add_stream(int n);
      int target, r, h;
      target = pending_q.size() + n;
      while (pending_q.size() < target) begin
         r = $urandom_range(0, 99);
         if (r < 2) begin
            add_restart();
         end else if (r < 70) begin
            // Baseline then a beat.
            repeat ($urandom_range(3, 40)) add_sample($urandom_range(0, 200));
            h = $urandom_range(1500, 30000);
            add_sample(h / 2);
            add_sample(h);
            add_sample(h / 3);
         end else if (r < 88) begin
            // Small peak, often between the two thresholds.
            repeat ($urandom_range(1, 10)) add_sample($urandom_range(0, 200));
            h = $urandom_range(300, 1800);
            add_sample(h / 2);
            add_sample(h);
            add_sample(h / 4);
         end else begin
            repeat ($urandom_range(1, 6)) add_sample($urandom_range(0, 65535));
         end
      end
   endtask

   initial begin
      int dir_a[10];
      int dir_b[7];
      dir_a = '{0, 16'hFFFF, 1, 16'h8000, 16'hAAAA, 16'h5555, 0, 16'hFFFE, 3, 0};
      dir_b = '{16'hFFFF, 0, 200, 16'h7FFF, 5, 16'hFFFF, 0};
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      n_errors = 0;
      n_sent = 0;
      n_beats = 0;
      n_search_hits = 0;
      sender_idle_pct = 38;
      receiver_idle_pct = 68;
      cfg_refractory = 50;
      cfg_sig_start = 4000;
      cfg_noise_start = 1000;
      cfg_rr_low = 0;
      cfg_rr_high = 4095;
      cfg_rr_miss = 4095;
      restart_detector();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: register extremes and sample extremes.
      write_registers(0, 16'hFFFF, 16'hFFFF, 4095, 0, 0);
      add_restart();
      foreach (dir_a[i]) add_sample(dir_a[i]);
      wait_drained();
      write_registers(4095, 0, 0, 0, 0, 4095);
      add_restart();
      foreach (dir_b[i]) add_sample(dir_b[i]);
      add_restart();
      wait_drained();

      // Random phase one, with a full pause of the sender halfway.
      write_registers(8, 4000, 1000, 0, 4095, 4095);
      add_restart();
      add_stream(100);
      wait_drained();
      add_stream(100);
      wait_drained();

      sender_idle_pct = 68;
      receiver_idle_pct = 38;
      write_registers(20, 8000, 500, 10, 200, 90);
      add_restart();
      add_stream(200);
      wait_drained();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      write_registers(5, 3000, 2000, 0, 4095, 40);
      add_restart();
      add_stream(200);
      wait_drained();

      $display("Covered %0d samples over five register settings: %0d R peaks, %0d from search-back.",
               n_sent, n_beats, n_search_hits);
      if (n_errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
